### sv/crc_checked_frame_deframer_assert.svh
// Assertion macros shared by the deframer RTL.
// Needs a clock and an active-high reset named by the caller.
`ifndef CRC_CHECKED_FRAME_DEFRAMER_ASSERT_SVH
`define CRC_CHECKED_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CCFD_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CCFD_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

### sv/ccfd_pkg.sv
// Shared types, constants and the CRC step for the frame deframer.
// No dependencies.
`timescale 1ns / 1ps

package ccfd_pkg;

   // Frame parser states
   typedef enum logic [2:0] {
      ST_HUNT,
      ST_LEN,
      ST_ID,
      ST_PAYLOAD,
      ST_CRC_LO,
      ST_CRC_HI
   } frm_state_type;

   localparam logic [7:0]  START_BYTE = 8'h52;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h8408;

   // Reflected CCITT CRC, one byte folded in (eight bit steps)
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### sv/ccfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ccfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

### sv/crc_checked_frame_deframer.sv
// Start byte / length / CRC-16 frame deframer, top level.
// Uses ccfd_pkg, ccfd_ram and crc_checked_frame_deframer_assert.svh.
`timescale 1ns / 1ps
//
// Usage:
//   req_ channel: one received byte per item (req_rx_byte). A frame is
//   0x52, length, id, payload bytes, CRC low, CRC high. Frames with a
//   matching CRC come out on the rsp_ channel as one item per payload
//   byte (one item with rsp_has_byte low for an empty payload), rsp_last
//   marking the final item. Bad or oversize frames produce nothing.
//   Throughput: one input byte per cycle while req_stall is low. The payload
//   memory holds two frame banks, so a frame can be received while the
//   previous one is read out. Readout gives one item per cycle while the
//   output is not stalled. Once the CRC high byte is accepted, the readout
//   control starts, then each item passes the RAM read and the output register.
//   req_stall rises only while the CRC high byte waits and the previous
//   frame still has reads to issue; that is the only input backpressure.
//   When rsp_stall is high with an item on the output, the output register
//   and the pending read hold, and readout resumes without loss.
//   Reset (synchronous) returns the parser to hunting for the start byte
//   and empties the readout path; the payload memory is not cleared.
//
module crc_checked_frame_deframer #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_message_id,
   output logic [5:0] rsp_payload_length,
   output logic [4:0] rsp_byte_index,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_has_byte,
   output logic       rsp_last
);

`include "crc_checked_frame_deframer_assert.svh"

   localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
   localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int AW    = IDX_W + 1;
   localparam int DEPTH = 1 << AW;

   // Parser registers
   ccfd_pkg::frm_state_type state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       id_ff, id_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       crc_lo_ff, crc_lo_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic             wr_bank_ff, wr_bank_in;
   logic             mem_we;
   logic             handoff;
   logic             req_fire;

   // Readout registers
   logic             rd_active_ff;
   logic             rd_bank_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [LEN_W-1:0] rd_len_ff;
   logic [7:0]       rd_id_ff;
   logic             rd_empty_ff;
   logic             rd_last;
   logic             advance;
   logic             issue;

   // Read stage (data sits in the RAM output register)
   logic             s1_valid_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic [LEN_W-1:0] s1_len_ff;
   logic [7:0]       s1_id_ff;
   logic             s1_has_ff;
   logic             s1_last_ff;

   // Output register
   logic             rsp_valid_ff;
   logic [7:0]       rsp_id_ff;
   logic [LEN_W-1:0] rsp_len_ff;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_has_ff;
   logic             rsp_last_ff;

   logic [7:0]       mem_rd_data;

   // Hold the CRC high byte while the other bank still has reads to issue
   assign req_stall = (state_ff == ccfd_pkg::ST_CRC_HI) && rd_active_ff;
   assign req_fire  = req_valid && !req_stall;

   // Parser state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ccfd_pkg::ST_HUNT;
         wr_bank_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wr_bank_ff <= wr_bank_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff    <= len_in;
      id_ff     <= id_in;
      crc_ff    <= crc_in;
      crc_lo_ff <= crc_lo_in;
      wr_idx_ff <= wr_idx_in;
   end

   // Parser next state, payload writes and frame handoff
   always_comb begin
      state_in   = state_ff;
      len_in     = len_ff;
      id_in      = id_ff;
      crc_in     = crc_ff;
      crc_lo_in  = crc_lo_ff;
      wr_idx_in  = wr_idx_ff;
      wr_bank_in = wr_bank_ff;
      mem_we     = 1'b0;
      handoff    = 1'b0;
      if (req_fire) begin
         unique case (state_ff)
            ccfd_pkg::ST_HUNT: begin
               if (req_rx_byte == ccfd_pkg::START_BYTE) begin
                  crc_in   = ccfd_pkg::CRC_INIT;
                  state_in = ccfd_pkg::ST_LEN;
               end
            end
            ccfd_pkg::ST_LEN: begin
               if (req_rx_byte > 8'(MAX_PAYLOAD)) begin
                  state_in = ccfd_pkg::ST_HUNT;
               end else begin
                  len_in   = LEN_W'(req_rx_byte);
                  crc_in   = ccfd_pkg::crc_feed(crc_ff, req_rx_byte);
                  state_in = ccfd_pkg::ST_ID;
               end
            end
            ccfd_pkg::ST_ID: begin
               id_in     = req_rx_byte;
               crc_in    = ccfd_pkg::crc_feed(crc_ff, req_rx_byte);
               wr_idx_in = '0;
               state_in  = (len_ff == '0) ? ccfd_pkg::ST_CRC_LO : ccfd_pkg::ST_PAYLOAD;
            end
            ccfd_pkg::ST_PAYLOAD: begin
               mem_we    = 1'b1;
               crc_in    = ccfd_pkg::crc_feed(crc_ff, req_rx_byte);
               wr_idx_in = wr_idx_ff + IDX_W'(1);
               if (LEN_W'(wr_idx_ff) + LEN_W'(1) == len_ff) begin
                  state_in = ccfd_pkg::ST_CRC_LO;
               end
            end
            ccfd_pkg::ST_CRC_LO: begin
               crc_lo_in = req_rx_byte;
               state_in  = ccfd_pkg::ST_CRC_HI;
            end
            ccfd_pkg::ST_CRC_HI: begin
               state_in = ccfd_pkg::ST_HUNT;
               if ({req_rx_byte, crc_lo_ff} == crc_ff) begin
                  handoff    = 1'b1;
                  wr_bank_in = ~wr_bank_ff;
               end
            end
            default: begin
               state_in = ccfd_pkg::ST_HUNT;
            end
         endcase
      end
   end

   // Readout pipeline moves when the output register is free or taken
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign issue   = advance && rd_active_ff;
   assign rd_last = rd_empty_ff || (LEN_W'(rd_idx_ff) + LEN_W'(1) == rd_len_ff);

   // Two-bank payload memory: parser writes one bank, readout reads the other
   ccfd_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr ({wr_bank_ff, wr_idx_ff}),
      .wr_data (req_rx_byte),
      .rd_en   (advance),
      .rd_addr ({rd_bank_ff, rd_idx_ff}),
      .rd_data (mem_rd_data)
   );

   // Readout control and pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_active_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (handoff) begin
            rd_active_ff <= 1'b1;
         end else if (issue && rd_last) begin
            rd_active_ff <= 1'b0;
         end
         if (advance) begin
            s1_valid_ff  <= issue;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Readout payload registers
   always_ff @(posedge clock) begin
      if (handoff) begin
         rd_bank_ff  <= wr_bank_ff;
         rd_idx_ff   <= '0;
         rd_len_ff   <= len_ff;
         rd_id_ff    <= id_ff;
         rd_empty_ff <= (len_ff == '0);
      end else if (issue) begin
         rd_idx_ff <= rd_idx_ff + IDX_W'(1);
      end
      if (advance) begin
         s1_idx_ff   <= rd_idx_ff;
         s1_len_ff   <= rd_len_ff;
         s1_id_ff    <= rd_id_ff;
         s1_has_ff   <= !rd_empty_ff;
         s1_last_ff  <= rd_last;
         rsp_id_ff   <= s1_id_ff;
         rsp_len_ff  <= s1_len_ff;
         rsp_idx_ff  <= s1_idx_ff;
         rsp_byte_ff <= s1_has_ff ? mem_rd_data : 8'h00;
         rsp_has_ff  <= s1_has_ff;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_message_id     = rsp_id_ff;
   assign rsp_payload_length = 6'(rsp_len_ff);
   assign rsp_byte_index     = 5'(rsp_idx_ff);
   assign rsp_payload_byte   = rsp_byte_ff;
   assign rsp_has_byte       = rsp_has_ff;
   assign rsp_last           = rsp_last_ff;

   // Checks
   `CCFD_ASSERT_IMPL(a_handoff_idle, clock, reset, handoff, !rd_active_ff,
      "frame handed off while readout still active")
   `CCFD_ASSERT_IMPL(a_bank_split, clock, reset, rd_active_ff, rd_bank_ff != wr_bank_ff,
      "readout and parser share a payload bank")
   `CCFD_ASSERT_IMPL(a_rd_idx_range, clock, reset, rd_active_ff && !rd_empty_ff,
      LEN_W'(rd_idx_ff) < rd_len_ff, "readout index beyond frame length")
   `CCFD_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && rsp_valid_ff && rsp_stall,
      s1_valid_ff, "pending read dropped during output stall")

endmodule

### tb/tb.sv
// Self-checking bench for crc_checked_frame_deframer: byte frames in, payload items out.
// Depends on ccfd_pkg (states, start byte, CRC constants) and the deframer RTL.
`timescale 1ns / 1ps

module tb;

   localparam int FRAME_MAX   = 32;
   localparam int TAIL_CYCLES = 8;

   // One payload item as it leaves the block
   typedef struct packed {
      logic [7:0] message_id;
      logic [5:0] payload_length;
      logic [4:0] byte_index;
      logic [7:0] payload_byte;
      logic       has_byte;
      logic       last;
   } payload_item_type;

   // Frame parser mirror plus the queue of payload items still owed by the block
   class deframe_scoreboard;
      ccfd_pkg::frm_state_type parse_state;
      logic [7:0]    frame_len;
      logic [7:0]    frame_id;
      logic [7:0]    crc_low;
      logic [15:0]   crc_acc;
      logic [7:0]    payload_buf [FRAME_MAX];
      int unsigned   fill;
      payload_item_type expected_items [$];
      int unsigned   mismatches;
      int unsigned   items_checked;
      int unsigned   frames_passed;
      int unsigned   bytes_taken;

      function new();
         parse_state   = ccfd_pkg::ST_HUNT;
         frame_len     = 8'h00;
         frame_id      = 8'h00;
         crc_low       = 8'h00;
         crc_acc       = ccfd_pkg::CRC_INIT;
         fill          = 0;
         mismatches    = 0;
         items_checked = 0;
         frames_passed = 0;
         bytes_taken   = 0;
      endfunction

      // Reflected CCITT CRC, LSB first
      static function logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         c = crc ^ {8'h00, b};
         for (int k = 0; k < 8; k++) begin
            c = {1'b0, c[15:1]} ^ (c[0] ? ccfd_pkg::CRC_POLY : 16'h0000);
         end
         return c;
      endfunction

      // Note one accepted byte; queue the frame's items when its CRC matches
      function void take_byte(logic [7:0] b);
         payload_item_type item;
         if (!(parse_state == ccfd_pkg::ST_HUNT && b != ccfd_pkg::START_BYTE)) begin
            bytes_taken++;
         end
         case (parse_state)
            ccfd_pkg::ST_HUNT: begin
               if (b == ccfd_pkg::START_BYTE) begin
                  crc_acc     = ccfd_pkg::CRC_INIT;
                  parse_state = ccfd_pkg::ST_LEN;
               end
            end
            ccfd_pkg::ST_LEN: begin
               if (b > FRAME_MAX) begin
                  parse_state = ccfd_pkg::ST_HUNT;
               end else begin
                  frame_len   = b;
                  crc_acc     = crc_fold(crc_acc, b);
                  parse_state = ccfd_pkg::ST_ID;
               end
            end
            ccfd_pkg::ST_ID: begin
               frame_id    = b;
               crc_acc     = crc_fold(crc_acc, b);
               fill        = 0;
               parse_state = (frame_len == 0) ? ccfd_pkg::ST_CRC_LO : ccfd_pkg::ST_PAYLOAD;
            end
            ccfd_pkg::ST_PAYLOAD: begin
               payload_buf[fill] = b;
               fill++;
               crc_acc = crc_fold(crc_acc, b);
               if (fill == frame_len) begin
                  parse_state = ccfd_pkg::ST_CRC_LO;
               end
            end
            ccfd_pkg::ST_CRC_LO: begin
               crc_low     = b;
               parse_state = ccfd_pkg::ST_CRC_HI;
            end
            ccfd_pkg::ST_CRC_HI: begin
               parse_state = ccfd_pkg::ST_HUNT;
               if ({b, crc_low} == crc_acc) begin
                  frames_passed++;
                  item.message_id     = frame_id;
                  item.payload_length = frame_len[5:0];
                  if (frame_len == 0) begin
                     // empty payload: one marker item with no byte
                     item.byte_index   = 5'd0;
                     item.payload_byte = 8'h00;
                     item.has_byte     = 1'b0;
                     item.last         = 1'b1;
                     expected_items.push_back(item);
                  end else begin
                     for (int i = 0; i < frame_len; i++) begin
                        item.byte_index   = 5'(i);
                        item.payload_byte = payload_buf[i];
                        item.has_byte     = 1'b1;
                        item.last         = (i + 1 == frame_len);
                        expected_items.push_back(item);
                     end
                  end
               end
            end
            default: parse_state = ccfd_pkg::ST_HUNT;
         endcase
      endfunction

      // Compare one delivered item against the oldest owed item
      function void check_item(payload_item_type got);
         payload_item_type want;
         if (expected_items.size() == 0) begin
            $error("unexpected item: message_id %0h byte_index %0d", got.message_id,
                   got.byte_index);
            mismatches++;
            return;
         end
         want = expected_items.pop_front();
         items_checked++;
         if (got.message_id !== want.message_id) begin
            $error("message_id: expected %0h, got %0h", want.message_id, got.message_id);
            mismatches++;
         end
         if (got.payload_length !== want.payload_length) begin
            $error("payload_length: expected %0d, got %0d", want.payload_length,
                   got.payload_length);
            mismatches++;
         end
         if (got.byte_index !== want.byte_index) begin
            $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
            mismatches++;
         end
         if (got.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", want.payload_byte,
                   got.payload_byte);
            mismatches++;
         end
         if (got.has_byte !== want.has_byte) begin
            $error("has_byte: expected %0b, got %0b", want.has_byte, got.has_byte);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            mismatches++;
         end
      endfunction

      // Anything still owed at the end counts against the run
      function bit clean_finish();
         if (expected_items.size() != 0) begin
            $error("%0d expected items never delivered", expected_items.size());
            mismatches++;
         end
         return (mismatches == 0);
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_message_id;
   logic [5:0] rsp_payload_length;
   logic [4:0] rsp_byte_index;
   logic [7:0] rsp_payload_byte;
   logic       rsp_has_byte;
   logic       rsp_last;

   deframe_scoreboard sb = new();

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_request  = 0;
   int hold_left     = 0;

   crc_checked_frame_deframer #(
      .MAX_PAYLOAD(FRAME_MAX)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_message_id     (rsp_message_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_has_byte       (rsp_has_byte),
      .rsp_last           (rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Run limit, far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Receiver: long hold-off on request, otherwise random stalls
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_item({rsp_message_id, rsp_payload_length, rsp_byte_index,
                        rsp_payload_byte, rsp_has_byte, rsp_last});
      end
   end

   // Offer one byte, with random idle cycles ahead of it; returns at a falling edge
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid   <= 1'b0;
         req_rx_byte <= 8'($urandom);
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      sb.take_byte(b);
      @(negedge clock);
   endtask

   // Whole frame; pad < 0 gives random payload, otherwise every byte is pad
   task automatic send_frame(input int len, input logic [7:0] id, input int pad,
                             input bit bad_crc);
      logic [7:0]  body [$];
      logic [15:0] crc;
      body.push_back(8'(len));
      body.push_back(id);
      for (int i = 0; i < len; i++) begin
         body.push_back((pad < 0) ? 8'($urandom) : 8'(pad));
      end
      crc = ccfd_pkg::CRC_INIT;
      foreach (body[i]) crc = deframe_scoreboard::crc_fold(crc, body[i]);
      if (bad_crc) begin
         crc ^= 16'(1 << $urandom_range(15));
      end
      send_byte(ccfd_pkg::START_BYTE);
      foreach (body[i]) send_byte(body[i]);
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
   endtask

   // Mostly short payloads, now and then the largest
   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 8) return FRAME_MAX;
      if (r < 12) return FRAME_MAX - 1;
      if (r < 20) return $urandom_range(FRAME_MAX - 2, 7);
      return $urandom_range(6);
   endfunction

   // Mixed traffic until quota more frame bytes have been taken
   task automatic random_traffic(input int unsigned quota);
      int unsigned target;
      int          pick;
      target = sb.bytes_taken + quota;
      while (sb.bytes_taken < target) begin
         pick = $urandom_range(99);
         if (pick < 68) begin
            send_frame(pick_length(), 8'($urandom), -1, 1'b0);
         end else if (pick < 80) begin
            send_frame(pick_length(), 8'($urandom), -1, 1'b1);
         end else if (pick < 88) begin
            send_byte(ccfd_pkg::START_BYTE);
            send_byte(8'($urandom_range(255, FRAME_MAX + 1)));
         end else begin
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
         end
      end
   endtask

   // Stop offering, wait for every owed item, then let the pipeline settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_items.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Idle/stall settings change between edges while the input is quiet
   task automatic phase_setup(input int sender_pct, input int receiver_pct,
                              input int hold_cycles);
      @(posedge clock);
      req_idle_pct  = sender_pct;
      rsp_stall_pct = receiver_pct;
      hold_request  = hold_cycles;
      @(negedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: noise, empty, bad CRC, oversize, start byte as data, all-ones
      phase_setup(0, 0, 0);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hA5);
      send_frame(0, 8'h00, -1, 1'b0);
      send_frame(0, 8'hFF, -1, 1'b1);
      send_byte(ccfd_pkg::START_BYTE);
      send_byte(8'(FRAME_MAX + 1));
      send_byte(ccfd_pkg::START_BYTE);
      send_byte(8'hFF);
      send_frame(1, ccfd_pkg::START_BYTE, ccfd_pkg::START_BYTE, 1'b0);
      send_frame(2, 8'hFF, 8'hFF, 1'b0);
      wait_drained();

      // Long receiver hold-off while full-size frames keep coming
      phase_setup(0, 0, 300);
      repeat (3) send_frame(FRAME_MAX, 8'($urandom), -1, 1'b0);
      random_traffic(75);
      wait_drained();

      phase_setup(53, 0, 0);
      random_traffic(75);
      wait_drained();

      phase_setup(0, 53, 0);
      random_traffic(75);
      wait_drained();

      phase_setup(21, 21, 0);
      random_traffic(75);
      wait_drained();

      $display("Covered %0d frame bytes, %0d good frames, %0d payload items checked,",
               sb.bytes_taken, sb.frames_passed, sb.items_checked);
      $display("over free-running, sender-idle, receiver-stall and mixed phases.");
      if (sb.clean_finish()) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### crc_checked_frame_deframer.f
+incdir+sv
sv/ccfd_pkg.sv
sv/ccfd_ram.sv
sv/crc_checked_frame_deframer.sv
tb/tb.sv
